// ----- hdl/key_button_qualifier_core_assert.svh -----
// Assertion macros shared by the key button qualifier RTL.
`ifndef KEY_BUTTON_QUALIFIER_CORE_ASSERT_SVH
`define KEY_BUTTON_QUALIFIER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define KBQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define KBQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KBQ_ASSERT_IMPL(label, ante, cons, msg)
`define KBQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/kbq_pkg.sv -----
// Types, codes and the key code table of the key button qualifier.
`timescale 1ns / 1ps

package kbq_pkg;

   localparam int NavCount = 10;

   typedef logic [9:0] key_code_type;
   typedef logic [3:0] key_index_type;
   typedef logic [1:0] key_value_type;
   typedef logic [1:0] csr_index_type;

   // Key value codes of an input event.
   localparam key_value_type KEY_RELEASE = 2'd0;
   localparam key_value_type KEY_PRESS   = 2'd1;
   localparam key_value_type KEY_REPEAT  = 2'd2;

   // Configuration register indexes.
   localparam csr_index_type CSR_DEBOUNCE   = 2'd0;
   localparam csr_index_type CSR_QUIET      = 2'd1;
   localparam csr_index_type CSR_LONG_PRESS = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [15:0] QUIET_RESET      = 16'd200;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd2000;

   localparam key_code_type  CODE_POWER  = 10'd116;
   localparam key_index_type POWER_INDEX = 4'd10;

   // Navigation key codes in index order: up, down, left, right, menu, back,
   // shutter, file, F1, F2.
   localparam key_code_type NAV_CODES [NavCount] = '{
      10'd103, 10'd108, 10'd105, 10'd106, 10'd139,
      10'd158, 10'd167, 10'd144, 10'd59,  10'd60
   };

   typedef struct packed {
      logic          hit;
      key_index_type index;
   } nav_lookup_type;

   function automatic nav_lookup_type nav_lookup(key_code_type code);
      nav_lookup_type res;
      res = '0;
      for (int i = 0; i < NavCount; i++) begin
         if (NAV_CODES[i] == code) begin
            res.hit   = 1'b1;
            res.index = key_index_type'(i);
         end
      end
      return res;
   endfunction

endpackage

// ----- hdl/kbq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module kbq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 10,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/key_button_qualifier_core.sv -----
// Key button qualifier: debounce, bank quiet time and power long-press detection.
`timescale 1ns / 1ps

// Each transfer on the req_ channel is one input event and yields exactly one
// transfer on the rsp_ channel, in order. The block sustains one event per
// clock cycle while rsp_ready stays high. The press-time RAM read is issued at
// the request transfer; the event and the read data are held in stage one,
// where the read data is qualified, and the result is registered in the output
// register once that is free. The output register decouples the two sides, so
// a new event is taken into an empty stage one while a finished result still
// waits for rsp_ready. Back-to-back events on the same key are handled by
// forwarding the press time just written. The debounce, quiet and long-press
// times are written through the csr_ port and should only change while no
// event is in flight. All times are milliseconds, taken modulo 2^TIME_BITS; an
// elapsed time whose newer stamp is below the older one counts as zero.
module key_button_qualifier_core
   import kbq_pkg::*;
#(
   parameter int NUM_KEYS  = 10,
   parameter int TIME_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   // Configuration write port.
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata,
   // Event request channel.
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_is_key_event,
   input  key_code_type  req_key_code,
   input  key_value_type req_key_value,
   input  logic [31:0]   req_event_time_ms,
   input  logic          req_display_asleep,
   input  logic          req_wake_enable,
   // Result channel.
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_activity,
   output logic          rsp_key_valid,
   output key_index_type rsp_key_index,
   output logic          rsp_short_press,
   output logic          rsp_long_press
);

`include "key_button_qualifier_core_assert.svh"

   localparam int AddrW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [NUM_KEYS-1:0]  mask_type;

   // Elapsed time from the older to the newer stamp; zero when the newer one
   // is the smaller value.
   function automatic time_type elapsed(time_type newer, time_type older);
      return (newer < older) ? '0 : newer - older;
   endfunction

   // Configuration registers.
   logic [15:0] debounce_ff, quiet_ff, long_press_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         quiet_ff      <= QUIET_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            CSR_QUIET:      quiet_ff      <= csr_wdata;
            CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake control.
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s1_adv, req_accept;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   // Decode of the incoming event; the press-time read is issued here.
   nav_lookup_type req_nav;
   logic           req_nav_hit, req_power;
   logic [AddrW-1:0] req_addr;
   time_type       req_now;

   assign req_nav     = nav_lookup(req_key_code);
   assign req_power   = req_is_key_event && (req_key_code == CODE_POWER);
   assign req_nav_hit = req_is_key_event && !req_power && req_nav.hit &&
                        (int'(req_nav.index) < NUM_KEYS);
   assign req_addr    = req_nav_hit ? AddrW'(req_nav.index) : '0;
   assign req_now     = TIME_BITS'({16'd0, req_event_time_ms});

   // Stage one: the event with its press time from the RAM.
   logic             s1_power_ff, s1_nav_ff, s1_suppress_ff, s1_wake_ff;
   key_index_type    s1_idx_ff;
   logic [AddrW-1:0] s1_addr_ff;
   key_value_type    s1_value_ff;
   time_type         s1_now_ff;
   logic             fwd_hit_ff, fwd_hit_in;
   time_type         fwd_data_ff;

   // State kept in flip-flops.
   mask_type pressed_ff, pressed_in, timed_ff, timed_in;
   time_type release_time_ff, release_time_in;
   logic     release_seen_ff, release_seen_in;
   logic     power_held_ff, power_held_in;
   time_type pwr_press_ff, pwr_press_in;

   // Press-time memory.
   logic     ram_we;
   time_type ram_rdata, press_time;

   kbq_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (NUM_KEYS)
   ) u_press_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_now_ff),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   // A write in the same cycle as a read of the same key is not seen by the
   // read port, so the written time is kept aside and used instead.
   assign fwd_hit_in = ram_we && (s1_addr_ff == req_addr);
   assign press_time = fwd_hit_ff ? fwd_data_ff : ram_rdata;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_power_ff    <= req_power;
         s1_nav_ff      <= req_nav_hit;
         s1_idx_ff      <= req_nav.index;
         s1_addr_ff     <= req_addr;
         s1_value_ff    <= req_key_value;
         s1_now_ff      <= req_now;
         s1_suppress_ff <= req_display_asleep;
         s1_wake_ff     <= req_wake_enable;
         fwd_data_ff    <= s1_now_ff;
      end
   end

   // Qualification logic.
   mask_type s1_bit;
   logic     quiet, debounced, busy, qualified, power_release;
   logic     held_long;
   logic     res_activity, res_key_valid, res_short, res_long;
   key_index_type res_index;

   assign s1_bit = mask_type'(1) << s1_idx_ff;

   // The bank is quiet when no release was seen or enough time has passed.
   assign quiet = !release_seen_ff ||
                  (elapsed(s1_now_ff, release_time_ff) >= TIME_BITS'(quiet_ff));

   // A key is debounced when its last accepted press is too recent.
   assign debounced = ((timed_ff & s1_bit) != '0) &&
                      (elapsed(s1_now_ff, press_time) < TIME_BITS'(debounce_ff));

   assign busy      = (pressed_ff != '0) || power_held_ff;
   assign qualified = !debounced && !busy && quiet;

   // A power release is reported when the key was held, or when the display
   // sleeps and wake by key press is not allowed.
   assign power_release = power_held_ff || (s1_suppress_ff && !s1_wake_ff);
   assign held_long = power_held_ff ?
                      (elapsed(s1_now_ff, pwr_press_ff) >= TIME_BITS'(long_press_ff)) :
                      (long_press_ff == 16'd0);

   always_comb begin
      pressed_in      = pressed_ff;
      timed_in        = timed_ff;
      release_time_in = release_time_ff;
      release_seen_in = release_seen_ff;
      power_held_in   = power_held_ff;
      pwr_press_in    = pwr_press_ff;
      ram_we          = 1'b0;
      res_activity    = 1'b0;
      res_key_valid   = 1'b0;
      res_index       = '0;
      res_short       = 1'b0;
      res_long        = 1'b0;
      if (s1_power_ff) begin
         res_activity = 1'b1;
         case (s1_value_ff)
            KEY_PRESS: begin
               if (quiet && (pressed_ff == '0) && !power_held_ff) begin
                  power_held_in = 1'b1;
                  pwr_press_in  = s1_now_ff;
               end
            end
            KEY_RELEASE: begin
               if (power_release) begin
                  power_held_in = 1'b0;
                  res_long      = held_long;
                  res_short     = !held_long;
               end
               release_time_in = s1_now_ff;
               release_seen_in = 1'b1;
            end
            default: ;
         endcase
      end else if (s1_nav_ff) begin
         res_activity = 1'b1;
         case (s1_value_ff)
            KEY_RELEASE: begin
               pressed_in      = pressed_ff & ~s1_bit;
               release_time_in = s1_now_ff;
               release_seen_in = 1'b1;
            end
            KEY_PRESS: begin
               if ((pressed_ff & s1_bit) == '0) begin
                  pressed_in = pressed_ff | s1_bit;
                  if (qualified) begin
                     ram_we   = s1_adv;
                     timed_in = timed_ff | s1_bit;
                     if (!s1_suppress_ff || s1_wake_ff) begin
                        res_key_valid = 1'b1;
                        res_index     = s1_suppress_ff ? POWER_INDEX : s1_idx_ff;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff      <= '0;
         timed_ff        <= '0;
         release_seen_ff <= 1'b0;
         power_held_ff   <= 1'b0;
      end else if (s1_adv) begin
         pressed_ff      <= pressed_in;
         timed_ff        <= timed_in;
         release_seen_ff <= release_seen_in;
         power_held_ff   <= power_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         release_time_ff <= release_time_in;
         pwr_press_ff    <= pwr_press_in;
      end
   end

   // Output register.
   logic          rsp_activity_ff, rsp_key_valid_ff, rsp_short_ff, rsp_long_ff;
   key_index_type rsp_index_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_activity_ff  <= res_activity;
         rsp_key_valid_ff <= res_key_valid;
         rsp_index_ff     <= res_index;
         rsp_short_ff     <= res_short;
         rsp_long_ff      <= res_long;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_activity    = rsp_activity_ff;
   assign rsp_key_valid   = rsp_key_valid_ff;
   assign rsp_key_index   = rsp_index_ff;
   assign rsp_short_press = rsp_short_ff;
   assign rsp_long_press  = rsp_long_ff;

   // A stalled stage one must hold off new requests.
   `KBQ_ASSERT_IMPL(a_stall_blocks_req, s1_valid_ff && !out_free, !req_ready,
                    "request taken while stage one is stalled")
   // A written press time always leaves its key marked as timed.
   `KBQ_ASSERT_NEXT(a_write_sets_timed, ram_we, (timed_ff & $past(s1_bit)) != '0,
                    "press time written without timed mark")
   // A power release is either short or long, never both.
   `KBQ_ASSERT_IMPL(a_power_exclusive, rsp_valid_ff,
                    !(rsp_short_ff && rsp_long_ff),
                    "short and long power reported together")

endmodule

// ----- tb/sv/tb_key_button_qualifier_core.sv -----
// Self-checking testbench for the key button qualifier core.
`timescale 1ns / 1ps

module tb_key_button_qualifier_core;
   import kbq_pkg::*;

   // Key value 3 is outside the defined codes; the block treats it like autorepeat.
   localparam key_value_type KEY_VALUE_SPARE = 2'd3;
   // A code inside the field range that maps to neither a navigation key nor power.
   localparam key_code_type CODE_UNMAPPED = 10'd767;

   // Navigation key slots, in the order of NAV_CODES.
   localparam int KeyUp    = 0;
   localparam int KeyDown  = 1;
   localparam int KeyLeft  = 2;
   localparam int KeyRight = 3;
   localparam int KeyMenu  = 4;
   localparam int KeyF2    = 9;

   // One input event and one qualification report, as seen on the ports.
   typedef struct packed {
      logic          is_key;
      key_code_type  code;
      key_value_type value;
      logic [31:0]   stamp;
      logic          suppress;
      logic          wake;
   } key_event_type;

   typedef struct packed {
      logic          activity;
      logic          key_valid;
      key_index_type index;
      logic          short_press;
      logic          long_press;
   } qual_report_type;

   // Clock and reset. Reset is held from time zero and released once.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // Every block input has a known value from the start of the run.
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_DEBOUNCE;
   logic [15:0]   csr_wdata = '0;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_is_key_event = 1'b0;
   key_code_type  req_key_code = '0;
   key_value_type req_key_value = KEY_RELEASE;
   logic [31:0]   req_event_time_ms = '0;
   logic          req_display_asleep = 1'b0;
   logic          req_wake_enable = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_activity;
   logic          rsp_key_valid;
   key_index_type rsp_key_index;
   logic          rsp_short_press;
   logic          rsp_long_press;

   key_button_qualifier_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_is_key_event   (req_is_key_event),
      .req_key_code       (req_key_code),
      .req_key_value      (req_key_value),
      .req_event_time_ms  (req_event_time_ms),
      .req_display_asleep (req_display_asleep),
      .req_wake_enable    (req_wake_enable),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_activity       (rsp_activity),
      .rsp_key_valid      (rsp_key_valid),
      .rsp_key_index      (rsp_key_index),
      .rsp_short_press    (rsp_short_press),
      .rsp_long_press     (rsp_long_press)
   );

   // ------------------------------------------------------------------------
   // Predictor state: a private copy of the thresholds and of the key bank.
   // ------------------------------------------------------------------------
   logic [15:0]         debounce_cfg;
   logic [15:0]         quiet_cfg;
   logic [15:0]         hold_limit_cfg;
   logic [NavCount-1:0] held_keys;      // navigation keys currently down
   logic [NavCount-1:0] stamped_keys;   // keys that have an accepted press time
   logic [31:0]         press_stamp [NavCount];
   logic [31:0]         last_release;
   logic                release_valid;
   logic                power_pressed;
   logic [31:0]         power_stamp;

   // Reports predicted for accepted events, oldest first.
   qual_report_type predicted_reports [$];

   // Stimulus context shared by the test tasks.
   logic [31:0] wall_ms = '0;   // running event timestamp
   logic        asleep = 1'b0;  // drives the display-asleep flag on taps
   logic        wake_ok = 1'b0; // drives the wake-enable flag on taps
   logic        no_idle = 1'b0; // switches off random gaps and stalls on both sides

   int events_sent = 0;
   int reports_checked = 0;
   int key_reports = 0;
   int wake_reports = 0;
   int short_releases = 0;
   int long_releases = 0;
   int mismatch_count = 0;

   // Elapsed time between two stamps; a newer stamp below the older one
   // counts as no time at all.
   function automatic logic [31:0] elapsed_ms(logic [31:0] newer, logic [31:0] older);
      return (newer < older) ? 32'd0 : newer - older;
   endfunction

   // The bank is quiet when no release was ever seen or the last one is old enough.
   function automatic logic bank_is_calm(logic [31:0] now);
      return !release_valid || (elapsed_ms(now, last_release) >= {16'd0, quiet_cfg});
   endfunction

   task automatic clear_key_bank();
      debounce_cfg   = DEBOUNCE_RESET;
      quiet_cfg      = QUIET_RESET;
      hold_limit_cfg = LONG_PRESS_RESET;
      held_keys      = '0;
      stamped_keys   = '0;
      release_valid  = 1'b0;
      power_pressed  = 1'b0;
   endtask

   // Works out the report of one event and moves the key bank on.
   function automatic qual_report_type qualify_event(key_event_type ev);
      qual_report_type rep;
      int           slot;
      logic [31:0]  hold;
      logic         bounced;
      logic         busy;
      logic         calm;
      rep  = '0;
      slot = -1;
      for (int i = 0; i < NavCount; i++) begin
         if (NAV_CODES[i] == ev.code) slot = i;
      end
      if (ev.is_key && ev.code == CODE_POWER) begin
         rep.activity = 1'b1;
         if (ev.value == KEY_PRESS) begin
            if (bank_is_calm(ev.stamp) && held_keys == '0 && !power_pressed) begin
               power_pressed = 1'b1;
               power_stamp   = ev.stamp;
            end
         end else if (ev.value == KEY_RELEASE) begin
            // A release with power not held still reports while asleep
            // without wake permission, as a zero-length hold.
            if (power_pressed || (ev.suppress && !ev.wake)) begin
               hold          = power_pressed ? elapsed_ms(ev.stamp, power_stamp) : 32'd0;
               power_pressed = 1'b0;
               if (hold >= {16'd0, hold_limit_cfg}) rep.long_press = 1'b1;
               else rep.short_press = 1'b1;
            end
            last_release  = ev.stamp;
            release_valid = 1'b1;
         end
      end else if (ev.is_key && slot >= 0) begin
         rep.activity = 1'b1;
         if (ev.value == KEY_RELEASE) begin
            held_keys[slot] = 1'b0;
            last_release    = ev.stamp;
            release_valid   = 1'b1;
         end else if (ev.value == KEY_PRESS && !held_keys[slot]) begin
            bounced = stamped_keys[slot] &&
                      (elapsed_ms(ev.stamp, press_stamp[slot]) < {16'd0, debounce_cfg});
            busy    = (held_keys != '0) || power_pressed;
            calm    = bank_is_calm(ev.stamp);
            held_keys[slot] = 1'b1;
            if (!bounced && !busy && calm) begin
               press_stamp[slot]  = ev.stamp;
               stamped_keys[slot] = 1'b1;
               if (!ev.suppress || ev.wake) begin
                  rep.key_valid = 1'b1;
                  rep.index     = ev.suppress ? POWER_INDEX : key_index_type'(slot);
               end
            end
         end
      end
      return rep;
   endfunction

   // ------------------------------------------------------------------------
   // Result side. Outputs are sampled at the rising edge, so the values seen
   // here are the ones from before the edge. rsp_ready is dropped at random
   // with a probability of about 11 percent unless no_idle is set.
   // ------------------------------------------------------------------------
   qual_report_type oldest_report;

   function automatic void check_field(string field, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_reports.size() == 0) begin
               $display("%0t ns: result transfer with no report expected", $time);
               mismatch_count++;
            end else begin
               oldest_report = predicted_reports.pop_front();
               check_field("activity", 4'(oldest_report.activity), 4'(rsp_activity));
               check_field("key_valid", 4'(oldest_report.key_valid), 4'(rsp_key_valid));
               check_field("key_index", oldest_report.index, rsp_key_index);
               check_field("short_press", 4'(oldest_report.short_press),
                           4'(rsp_short_press));
               check_field("long_press", 4'(oldest_report.long_press),
                           4'(rsp_long_press));
               reports_checked++;
               if (oldest_report.key_valid && oldest_report.index == POWER_INDEX) wake_reports++;
               else if (oldest_report.key_valid) key_reports++;
               short_releases += int'(oldest_report.short_press);
               long_releases  += int'(oldest_report.long_press);
            end
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // Presents one event and waits for its transfer. Valid is left high on
   // return, so the caller must either send the next event in the same time
   // step or park the channel before time moves on.
   task automatic send_event(key_event_type ev);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_is_key_event   <= ev.is_key;
      req_key_code       <= ev.code;
      req_key_value      <= ev.value;
      req_event_time_ms  <= ev.stamp;
      req_display_asleep <= ev.suppress;
      req_wake_enable    <= ev.wake;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_reports.push_back(qualify_event(ev));
      events_sent++;
   endtask

   // A key event at the running time, advanced by gap (modulo 2^32, so a gap
   // near the top of the range steps the time backward).
   task automatic tap(key_code_type code, key_value_type value, logic [31:0] gap);
      key_event_type ev;
      wall_ms     = wall_ms + gap;
      ev.is_key   = 1'b1;
      ev.code     = code;
      ev.value    = value;
      ev.stamp    = wall_ms;
      ev.suppress = asleep;
      ev.wake     = wake_ok;
      send_event(ev);
   endtask

   // Parks the request channel and waits until every report has come back,
   // then lets the two-stage pipeline settle.
   task automatic drain_reports();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three thresholds; only called with the block idle.
   task automatic write_settings(logic [15:0] debounce, logic [15:0] calm_time,
                                 logic [15:0] hold_limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= debounce;
      @(posedge clock);
      csr_index <= CSR_QUIET;
      csr_wdata <= calm_time;
      @(posedge clock);
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= hold_limit;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      debounce_cfg   = debounce;
      quiet_cfg      = calm_time;
      hold_limit_cfg = hold_limit;
   endtask

   // Time steps aimed at the edges of the current thresholds, mixed with
   // short, long, huge and backward steps.
   function automatic logic [31:0] pick_gap();
      case ($urandom_range(11))
         0:       return 32'd0;
         1:       return $urandom_range(1, 20);
         2:       return {16'd0, quiet_cfg} - 32'd1;
         3:       return {16'd0, quiet_cfg};
         4:       return {16'd0, quiet_cfg} + 32'd1;
         5:       return {16'd0, debounce_cfg} - 32'd1;
         6:       return {16'd0, debounce_cfg};
         7:       return {16'd0, hold_limit_cfg} - 32'd1;
         8:       return {16'd0, hold_limit_cfg};
         9:       return $urandom;
         10:      return 32'd0 - $urandom_range(1, 300);
         default: return $urandom_range(0, 3000);
      endcase
   endfunction

   // Random traffic, mostly well-formed press and release gestures with
   // random timing, plus noise events with random fields and timestamps.
   task automatic run_key_traffic(int count);
      int            target;
      int            slot;
      int            other;
      key_event_type junk;
      target = events_sent + count;
      while (events_sent < target) begin
         asleep  = ($urandom_range(9) == 0);
         wake_ok = 1'($urandom_range(1));
         case ($urandom_range(19))
            0, 1, 2: begin
               junk.is_key = 1'($urandom_range(1));
               if ($urandom_range(1)) junk.code = 10'($urandom_range(767));
               else if ($urandom_range(1)) junk.code = CODE_POWER;
               else junk.code = NAV_CODES[$urandom_range(NavCount - 1)];
               junk.value    = 2'($urandom_range(3));
               wall_ms       = wall_ms + pick_gap();
               junk.stamp    = ($urandom_range(3) == 0) ? $urandom : wall_ms;
               junk.suppress = 1'($urandom_range(1));
               junk.wake     = 1'($urandom_range(1));
               send_event(junk);
            end
            3, 4, 5: begin
               tap(CODE_POWER, KEY_PRESS, pick_gap());
               if ($urandom_range(3) == 0) tap(CODE_POWER, KEY_REPEAT, $urandom_range(0, 100));
               if ($urandom_range(9) != 0) tap(CODE_POWER, KEY_RELEASE, pick_gap());
            end
            default: begin
               slot = $urandom_range(NavCount - 1);
               tap(NAV_CODES[slot], KEY_PRESS, pick_gap());
               if ($urandom_range(3) == 0) tap(NAV_CODES[slot], KEY_REPEAT, $urandom_range(0, 100));
               // A second key pressed while the first is down must be refused.
               if ($urandom_range(4) == 0) begin
                  other = $urandom_range(NavCount - 1);
                  tap(NAV_CODES[other], KEY_PRESS, pick_gap());
                  tap(NAV_CODES[other], KEY_RELEASE, pick_gap());
               end
               // Now and then a key is left down, so later presses see a busy bank.
               if ($urandom_range(9) != 0) tap(NAV_CODES[slot], KEY_RELEASE, pick_gap());
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Hand-picked events at the reset thresholds (debounce 50, quiet 200,
   // long press 2000), starting from an empty bank at time zero.
   task automatic test_directed_cases();
      key_event_type ev;
      // An event that is not a key event yields an all-zero report.
      ev = '{is_key: 1'b0, code: CODE_POWER, value: KEY_PRESS, stamp: 32'd0,
             suppress: 1'b0, wake: 1'b0};
      send_event(ev);
      // First press ever at time zero: no release seen yet, so it qualifies.
      tap(NAV_CODES[KeyUp], KEY_PRESS, 32'd0);
      // Autorepeat and the spare value only flag activity.
      tap(NAV_CODES[KeyUp], KEY_REPEAT, 32'd5);
      tap(NAV_CODES[KeyUp], KEY_VALUE_SPARE, 32'd1);
      // Another key while one is held is refused as busy.
      tap(NAV_CODES[KeyDown], KEY_PRESS, 32'd1);
      tap(NAV_CODES[KeyDown], KEY_RELEASE, 32'd1);
      tap(NAV_CODES[KeyUp], KEY_RELEASE, 32'd1);
      // Too soon after the last release: refused for quiet time.
      tap(NAV_CODES[KeyLeft], KEY_PRESS, 32'd10);
      tap(NAV_CODES[KeyLeft], KEY_RELEASE, 32'd0);
      // Exactly the quiet time after the last release: accepted.
      tap(NAV_CODES[KeyUp], KEY_PRESS, {16'd0, QUIET_RESET});
      tap(NAV_CODES[KeyUp], KEY_RELEASE, 32'd0);
      // A code that maps to no key is not recognised at all.
      tap(CODE_UNMAPPED, KEY_PRESS, 32'd3);
      // Power held exactly the long-press time, then one millisecond short of it.
      tap(CODE_POWER, KEY_PRESS, {16'd0, QUIET_RESET});
      tap(CODE_POWER, KEY_RELEASE, {16'd0, LONG_PRESS_RESET});
      tap(CODE_POWER, KEY_PRESS, {16'd0, QUIET_RESET});
      tap(CODE_POWER, KEY_RELEASE, {16'd0, LONG_PRESS_RESET} - 32'd1);
      // Power release without a press: reported short only when asleep
      // without wake permission.
      asleep  = 1'b1;
      wake_ok = 1'b0;
      tap(CODE_POWER, KEY_RELEASE, 32'd5);
      wake_ok = 1'b1;
      tap(CODE_POWER, KEY_RELEASE, 32'd5);
      // Asleep with wake allowed: a qualified press turns into a wake request.
      tap(NAV_CODES[KeyRight], KEY_PRESS, {16'd0, QUIET_RESET});
      asleep = 1'b0;
      tap(NAV_CODES[KeyRight], KEY_RELEASE, 32'd0);
      // Asleep without wake: the press is taken but nothing is reported.
      asleep  = 1'b1;
      wake_ok = 1'b0;
      tap(NAV_CODES[KeyMenu], KEY_PRESS, {16'd0, QUIET_RESET});
      asleep = 1'b0;
      tap(NAV_CODES[KeyMenu], KEY_RELEASE, 32'd0);
      // Power released at a stamp before its press counts as a zero hold.
      tap(CODE_POWER, KEY_PRESS, {16'd0, QUIET_RESET});
      tap(CODE_POWER, KEY_RELEASE, 32'hFFFF_FFFB);
      // The top of the time range, then a wrap back to zero.
      wall_ms = 32'hFFFF_FFFF;
      tap(NAV_CODES[KeyF2], KEY_PRESS, 32'd0);
      tap(NAV_CODES[KeyF2], KEY_RELEASE, 32'd1);
      drain_reports();
   endtask

   // All thresholds at zero, then all at their maximum.
   task automatic test_extreme_settings();
      write_settings(16'd0, 16'd0, 16'd0);
      run_key_traffic(70);
      drain_reports();
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_key_traffic(70);
      drain_reports();
   endtask

   // A long stretch with neither side idling, so events go back to back.
   task automatic test_steady_stream();
      write_settings(16'd20, 16'd40, 16'd300);
      no_idle = 1'b1;
      run_key_traffic(150);
      drain_reports();
      no_idle = 1'b0;
   endtask

   // Short bursts; between bursts the sender holds off until every report
   // is back, so the pipeline runs empty and refills.
   task automatic test_drain_pause();
      write_settings(DEBOUNCE_RESET, QUIET_RESET, LONG_PRESS_RESET);
      repeat (4) begin
         run_key_traffic(20);
         drain_reports();
      end
   endtask

   // A debounce-heavy setting with no quiet time, then two random settings.
   task automatic test_random_settings();
      write_settings(16'd300, 16'd0, 16'd100);
      run_key_traffic(50);
      drain_reports();
      repeat (2) begin
         write_settings(16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                        16'($urandom_range(0, 3000)));
         run_key_traffic(50);
         drain_reports();
      end
   endtask

   initial begin
      clear_key_bank();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_extreme_settings();
      test_steady_stream();
      test_drain_pause();
      test_random_settings();
      drain_reports();
      $display("Sent %0d events and checked %0d reports under reset, zero, maximum and random",
               events_sent, reports_checked);
      $display("thresholds: %0d key presses, %0d wakes, %0d short and %0d long power releases.",
               key_reports, wake_reports, short_releases, long_releases);
      if (mismatch_count == 0) begin
         $display("tb_key_button_qualifier_core: clean");
      end else begin
         $display("tb_key_button_qualifier_core: errors");
      end
      $finish;
   end

   // Watchdog: stops a run that hangs.
   initial begin
      #5_000_000;
      $display("Timeout with %0d reports still outstanding.", predicted_reports.size());
      $display("tb_key_button_qualifier_core: errors");
      $finish;
   end

endmodule
